// ===== rtl/core/grid_first_fit_rect_placer_defines.svh =====
// Assertion macros for the first-fit rectangle placer
`ifndef GRID_FIRST_FIT_RECT_PLACER_DEFINES_SVH
`define GRID_FIRST_FIT_RECT_PLACER_DEFINES_SVH

// Check a consequence in the same cycle
`define GFFRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle
`define GFFRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gffrp_pkg.sv =====
// Package: shared types and constants of the first-fit rectangle placer
package gffrp_pkg;

    localparam int MAX_SIDE_DEF = 512;
    localparam int MIN_SIDE     = 16;
    localparam int WORD_W       = 64;
    localparam int FIELD_W      = 9;
    localparam int OFS_W        = 10;
    localparam int SIDE_W       = 10;
    localparam int STEP_W       = 8;

    localparam logic [STEP_W-1:0] MAX_SPACING   = 8'd128;
    localparam logic [SIDE_W-1:0] SIDE_RESET    = 10'd512;
    localparam logic [STEP_W-1:0] SPACING_RESET = 8'd1;

    localparam logic REG_SURFACE_SIDE = 1'b0;
    localparam logic REG_SPACING      = 1'b1;

    localparam logic MODE_PLACE = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_COL,
        S_PRD,
        S_PCHK,
        S_CRD,
        S_CWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    typedef struct packed {
        logic               placed;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
    } res_t;

endpackage

// ===== rtl/core/grid_first_fit_rect_placer.sv =====
// Top level: configuration registers, stream ports, output register and core
//
// Usage
//   s_* : input stream. s_tuser[0] = mode (0 place, 1 clear map).
//         s_tdata = item_width [8:0], item_height [17:9], zero fill to 24 bits.
//   m_* : result stream, one transaction per input transaction.
//         m_tuser[0] = placed; m_tdata = pos_x [8:0], pos_y [17:9].
//   APB : register 0 surface_side at 0x0, register 1 spacing at 0x4.
// Timing
//   A place transaction steps through row tests, column tests, a read and check of each
//   sampled cell probed at each candidate origin and a read and write of each cell
//   claimed, all through shared offset and index adders and the single map port.
//   A clear transaction sweeps all MAX_SIDE^2/64 map words (4096 at MAX_SIDE 512)
//   one word a cycle, then returns its result.
//   One transaction is worked at a time; s_tready is high only while idle.
// Reset
//   Registers return to side 512, spacing 1, and the map is swept clear
//   before the first input transaction is taken.
// Stall
//   A finished result waits in the output register; the next transaction is
//   accepted meanwhile and its result is held in the core until m_tready.
module grid_first_fit_rect_placer #(
    parameter int MAX_SIDE = gffrp_pkg::MAX_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // item_width [8:0], item_height [17:9], zero [23:18]
    input  logic [0:0]  s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pos_x [8:0], pos_y [17:9], zero [23:18]
    output logic [0:0]  m_tuser,   // placed [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gffrp_pkg::*;

    localparam int DEPTH = (MAX_SIDE * MAX_SIDE + 63) / 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SIDE + 1024) + 1;

    logic [SIDE_W-1:0] side_cfg_reg;
    logic [STEP_W-1:0] step_cfg_reg;
    logic              cfg_wr;
    logic [CW-1:0]     side_ext, side_eff;
    logic [STEP_W-1:0] step_eff;

    logic     fire, core_ready, res_valid, res_take;
    res_t     res;
    res_t     out_reg;
    logic     out_valid_reg;
    mem_cmd_t cmd;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] wdata, rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= SIDE_RESET;
            step_cfg_reg <= SPACING_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SURFACE_SIDE)
            begin
                side_cfg_reg <= pwdata[SIDE_W-1:0];
            end
            else
            begin
                step_cfg_reg <= pwdata[STEP_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_SPACING)
        begin
            prdata = 32'(step_cfg_reg);
        end
        else
        begin
            prdata = 32'(side_cfg_reg);
        end
    end

    // saturate configuration to the usable range
    assign side_ext = CW'(side_cfg_reg);

    always_comb
    begin
        side_eff = side_ext;
        if (side_ext < CW'(MIN_SIDE))
        begin
            side_eff = CW'(MIN_SIDE);
        end
        else if (side_ext > CW'(MAX_SIDE))
        begin
            side_eff = CW'(MAX_SIDE);
        end
        step_eff = step_cfg_reg;
        if (step_cfg_reg == '0)
        begin
            step_eff = STEP_W'(1);
        end
        else if (step_cfg_reg > MAX_SPACING)
        begin
            step_eff = MAX_SPACING;
        end
    end

    assign s_tready = core_ready;
    assign fire     = s_tvalid && core_ready;
    assign res_take = !out_valid_reg || m_tready;

    gffrp_scan #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .mode        (s_tuser[0]),
        .item_width  (s_tdata[8:0]),
        .item_height (s_tdata[17:9]),
        .side        (side_eff),
        .step        (step_eff),
        .ready       (core_ready),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .cmd         (cmd),
        .addr        (addr),
        .wdata       (wdata),
        .rdata       (rdata)
    );

    gffrp_map #(
        .MAX_SIDE (MAX_SIDE)
    ) u_map (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.pos_y, out_reg.pos_x};
    assign m_tuser  = out_reg.placed;

endmodule

// ===== rtl/core/gffrp_map.sv =====
// Occupancy map: single-port word memory with registered read data
module gffrp_map #(
    parameter int MAX_SIDE = gffrp_pkg::MAX_SIDE_DEF,
    localparam int DEPTH   = (MAX_SIDE * MAX_SIDE + 63) / 64,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  gffrp_pkg::mem_cmd_t         cmd,
    input  logic [AW-1:0]               addr,
    input  logic [gffrp_pkg::WORD_W-1:0] wdata,
    output logic [gffrp_pkg::WORD_W-1:0] rdata
);
    import gffrp_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gffrp_scan.sv =====
// Scan sequencer: origin search, cell probe, claim and map clearing sweep
`include "grid_first_fit_rect_placer_defines.svh"

module gffrp_scan #(
    parameter int MAX_SIDE = gffrp_pkg::MAX_SIDE_DEF,
    localparam int DEPTH   = (MAX_SIDE * MAX_SIDE + 63) / 64,
    localparam int AW      = $clog2(DEPTH),
    localparam int CW      = $clog2(MAX_SIDE + 1024) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          mode,
    input  logic [gffrp_pkg::FIELD_W-1:0] item_width,
    input  logic [gffrp_pkg::FIELD_W-1:0] item_height,
    input  logic [CW-1:0]                 side,
    input  logic [gffrp_pkg::STEP_W-1:0]  step,
    output logic                          ready,
    output logic                          res_valid,
    input  logic                          res_take,
    output gffrp_pkg::res_t               res,
    output gffrp_pkg::mem_cmd_t           cmd,
    output logic [AW-1:0]                 addr,
    output logic [gffrp_pkg::WORD_W-1:0]  wdata,
    input  logic [gffrp_pkg::WORD_W-1:0]  rdata
);
    import gffrp_pkg::*;

    localparam int IW = CW + $clog2(MAX_SIDE);

    state_t state_reg, state_next;

    logic [OFS_W-1:0]  pw_reg, pw_next;
    logic [OFS_W-1:0]  ph_reg, ph_next;
    logic [CW-1:0]     side_reg, side_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IW-1:0]     srow_reg, srow_next;
    logic [CW-1:0]     x_reg, x_next;
    logic [CW-1:0]     y_reg, y_next;
    logic [IW-1:0]     row_reg, row_next;
    logic [IW-1:0]     orig_reg, orig_next;
    logic [IW-1:0]     line_reg, line_next;
    logic [IW-1:0]     cell_reg, cell_next;
    logic [OFS_W-1:0]  dx_reg, dx_next;
    logic [OFS_W-1:0]  dy_reg, dy_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              rep_reg, rep_next;
    res_t              res_reg, res_next;

    logic [OFS_W-1:0] dx_inc, dy_inc;
    logic [IW-1:0]    cell_inc, line_inc;
    logic             dx_more, dy_more, more;
    logic             y_end, x_end, hit, clr_last;

    // shared offset / index adders for probe and claim
    assign dx_inc   = dx_reg + OFS_W'(step_reg);
    assign dy_inc   = dy_reg + OFS_W'(step_reg);
    assign dx_more  = dx_inc < pw_reg;
    assign dy_more  = dy_inc < ph_reg;
    assign more     = dx_more || dy_more;
    assign cell_inc = cell_reg + IW'(step_reg);
    assign line_inc = line_reg + srow_reg;

    assign y_end    = (y_reg + CW'(ph_reg)) >= side_reg;
    assign x_end    = (x_reg + CW'(pw_reg)) >= side_reg;
    assign hit      = rdata[cell_reg[5:0]];
    assign clr_last = clr_reg == AW'(DEPTH - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = rep_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (fire)
                begin
                    state_next = (mode == MODE_PLACE) ? S_ROW : S_CLEAR;
                end
            end
            S_ROW:   state_next = y_end ? S_DONE : S_COL;
            S_COL:   state_next = x_end ? S_ROW : S_PRD;
            S_PRD:   state_next = S_PCHK;
            S_PCHK:
            begin
                if (hit)
                begin
                    state_next = S_COL;
                end
                else if (more)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:   state_next = S_CWR;
            S_CWR:   state_next = more ? S_CRD : S_DONE;
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ready     = 1'b0;
        res_valid = 1'b0;
        cmd       = '0;
        addr      = cell_reg[6 +: AW];
        wdata     = rdata | (WORD_W'(1) << cell_reg[5:0]);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr = 1'b1;
                addr   = clr_reg;
                wdata  = '0;
            end
            S_IDLE:  ready = 1'b1;
            S_PRD:   cmd.rd = 1'b1;
            S_CRD:   cmd.rd = 1'b1;
            S_CWR:   cmd.wr = 1'b1;
            S_DONE:  res_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        pw_next   = pw_reg;
        ph_next   = ph_reg;
        side_next = side_reg;
        step_next = step_reg;
        srow_next = srow_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        row_next  = row_reg;
        orig_next = orig_reg;
        line_next = line_reg;
        cell_next = cell_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        clr_next  = clr_reg;
        rep_next  = rep_reg;
        res_next  = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (fire)
                begin
                    pw_next   = OFS_W'(item_width) + OFS_W'(1);
                    ph_next   = OFS_W'(item_height) + OFS_W'(1);
                    side_next = side;
                    step_next = step;
                    srow_next = IW'(step) * IW'(MAX_SIDE);
                    y_next    = CW'(1);
                    row_next  = IW'(MAX_SIDE);
                    clr_next  = '0;
                    rep_next  = mode;
                    res_next  = '0;
                end
            end
            S_ROW:
            begin
                x_next    = CW'(1);
                orig_next = row_reg + IW'(1);
            end
            S_COL:
            begin
                if (x_end)
                begin
                    y_next   = y_reg + CW'(step_reg);
                    row_next = row_reg + srow_reg;
                end
                else
                begin
                    dx_next   = '0;
                    dy_next   = '0;
                    line_next = orig_reg;
                    cell_next = orig_reg;
                end
            end
            S_PCHK, S_CWR:
            begin
                if (state_reg == S_PCHK && hit)
                begin
                    x_next    = x_reg + CW'(step_reg);
                    orig_next = orig_reg + IW'(step_reg);
                end
                else if (dx_more)
                begin
                    dx_next   = dx_inc;
                    cell_next = cell_inc;
                end
                else if (dy_more)
                begin
                    dx_next   = '0;
                    dy_next   = dy_inc;
                    line_next = line_inc;
                    cell_next = line_inc;
                end
                else if (state_reg == S_PCHK)
                begin
                    dx_next   = '0;
                    dy_next   = '0;
                    line_next = orig_reg;
                    cell_next = orig_reg;
                end
                else
                begin
                    res_next.placed = 1'b1;
                    res_next.pos_x  = x_reg[FIELD_W-1:0];
                    res_next.pos_y  = y_reg[FIELD_W-1:0];
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg   <= pw_next;
        ph_reg   <= ph_next;
        side_reg <= side_next;
        step_reg <= step_next;
        srow_reg <= srow_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        row_reg  <= row_next;
        orig_reg <= orig_next;
        line_reg <= line_next;
        cell_reg <= cell_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

    `GFFRP_ASSERT_NOW(a_idle_quiet, state_reg == S_IDLE, !cmd.wr && !cmd.rd, "map access while idle")
    `GFFRP_ASSERT_NEXT(a_fire_busy, fire, state_reg != S_IDLE, "transaction accepted but sequencer idle")
    `GFFRP_ASSERT_NOW(a_fail_zero, res_valid && !res.placed, res.pos_x == '0 && res.pos_y == '0, "failed result carries an origin")
    `GFFRP_ASSERT_NOW(a_claim_bit, state_reg == S_CWR, wdata[cell_reg[5:0]] == 1'b1, "claim write misses its cell")

endmodule

// ===== verif/rect_place_checker.sv =====
// Checker: predicts first-fit origins and compares them with the result stream
module rect_place_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // item_width [8:0], item_height [17:9], zero [23:18]
    input  logic [0:0]  s_tuser,   // mode [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // pos_x [8:0], pos_y [17:9], zero [23:18]
    input  logic [0:0]  m_tuser,   // placed [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          origins_pending
);

    localparam int MAP_SIDE = gffrp_pkg::MAX_SIDE_DEF;
    localparam logic [2:0] ADDR_SIDE    = {gffrp_pkg::REG_SURFACE_SIDE, 2'b00};
    localparam logic [2:0] ADDR_SPACING = {gffrp_pkg::REG_SPACING, 2'b00};

    logic [gffrp_pkg::SIDE_W-1:0] side_reg;
    logic [gffrp_pkg::STEP_W-1:0] step_reg;
    bit   [MAP_SIDE-1:0]          occupied [MAP_SIDE];
    gffrp_pkg::res_t              origins_due [$];
    gffrp_pkg::res_t              oldest;
    int                           errs;

    function automatic void wipe_map();
        foreach (occupied[i])
        begin
            occupied[i] = '0;
        end
    endfunction

    function automatic gffrp_pkg::res_t first_fit_origin(input logic [8:0] w,
                                                         input logic [8:0] h);
        int pw;
        int ph;
        int side;
        int step;
        int x;
        int y;
        int dx;
        int dy;
        bit hit;
        gffrp_pkg::res_t r;
        r    = '0;
        pw   = int'(w) + 1;
        ph   = int'(h) + 1;
        side = int'(side_reg);
        if (side < gffrp_pkg::MIN_SIDE)
            side = gffrp_pkg::MIN_SIDE;
        if (side > MAP_SIDE)
            side = MAP_SIDE;
        step = int'(step_reg);
        if (step < 1)
            step = 1;
        if (step > int'(gffrp_pkg::MAX_SPACING))
            step = int'(gffrp_pkg::MAX_SPACING);
        for (y = 1; y + 1 < side; y += step)
        begin
            if (y + ph >= side)
                break;
            for (x = 1; x + 1 < side; x += step)
            begin
                if (x + pw >= side)
                    break;
                hit = 1'b0;
                for (dy = 0; dy < ph && !hit; dy += step)
                begin
                    for (dx = 0; dx < pw && !hit; dx += step)
                    begin
                        if (occupied[y + dy][x + dx])
                            hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    for (dy = 0; dy < ph; dy += step)
                    begin
                        for (dx = 0; dx < pw; dx += step)
                        begin
                            occupied[y + dy][x + dx] = 1'b1;
                        end
                    end
                    r.placed = 1'b1;
                    r.pos_x  = 9'(x);
                    r.pos_y  = 9'(y);
                    return r;
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errs++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            side_reg = gffrp_pkg::SIDE_RESET;
            step_reg = gffrp_pkg::SPACING_RESET;
            wipe_map();
            origins_due.delete();
            errs = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_SIDE)
                    side_reg = pwdata[gffrp_pkg::SIDE_W-1:0];
                else if (paddr == ADDR_SPACING)
                    step_reg = pwdata[gffrp_pkg::STEP_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == gffrp_pkg::MODE_PLACE)
                begin
                    origins_due = {origins_due,
                                   first_fit_origin(s_tdata[8:0], s_tdata[17:9])};
                end
                else
                begin
                    wipe_map();
                    origins_due = {origins_due, gffrp_pkg::res_t'('0)};
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (origins_due.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result, expected none actual placed %0d x %0d y %0d",
                             $time, m_tuser[0], m_tdata[8:0], m_tdata[17:9]);
                end
                else
                begin
                    oldest = origins_due.pop_front();
                    report_field("placed", int'(oldest.placed), int'(m_tuser[0]));
                    report_field("pos_x", int'(oldest.pos_x), int'(m_tdata[8:0]));
                    report_field("pos_y", int'(oldest.pos_y), int'(m_tdata[17:9]));
                end
            end
        end
        mismatches      <= errs;
        origins_pending <= origins_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives rectangle placements and clears, and gives the verdict
module tb;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 40;
    localparam logic MODE_CLEAR = ~gffrp_pkg::MODE_PLACE;
    localparam logic [2:0] ADDR_SIDE    = {gffrp_pkg::REG_SURFACE_SIDE, 2'b00};
    localparam logic [2:0] ADDR_SPACING = {gffrp_pkg::REG_SPACING, 2'b00};

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // item_width [8:0], item_height [17:9], zero [23:18]
    logic [0:0]  s_tuser  = '0;   // mode [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // pos_x [8:0], pos_y [17:9], zero [23:18]
    logic [0:0]  m_tuser;         // placed [0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int origins_pending;
    int src_idle_pct = 6;
    int snk_idle_pct = 47;
    int eff_side     = gffrp_pkg::MAX_SIDE_DEF;
    int eff_step     = 1;
    int cycle_count  = 0;
    int side_set [PHASES] = '{16, 512, 64, 32, 1023, 0, 48, 200, 24, 512, 17, 100, 37, 300};
    int step_set [PHASES] = '{1, 128, 3, 1, 255, 0, 2, 9, 1, 40, 200, 4, 5, 16};

    grid_first_fit_rect_placer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rect_place_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .origins_pending (origins_pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (origins_pending != 0 || !s_tready);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_surface(input int side_val, input int step_val);
        drain();
        write_reg(ADDR_SIDE, ($urandom() & 32'hFFFF_FC00) | (side_val & 32'h3FF));
        write_reg(ADDR_SPACING, ($urandom() & 32'hFFFF_FF00) | (step_val & 32'hFF));
        eff_side = side_val & 32'h3FF;
        if (eff_side < gffrp_pkg::MIN_SIDE)
            eff_side = gffrp_pkg::MIN_SIDE;
        if (eff_side > gffrp_pkg::MAX_SIDE_DEF)
            eff_side = gffrp_pkg::MAX_SIDE_DEF;
        eff_step = step_val & 32'hFF;
        if (eff_step < 1)
            eff_step = 1;
        if (eff_step > int'(gffrp_pkg::MAX_SPACING))
            eff_step = int'(gffrp_pkg::MAX_SPACING);
    endtask

    task automatic send_item(input logic mode, input logic [8:0] w, input logic [8:0] h);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, h, w};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic random_item();
        logic [8:0] w;
        logic [8:0] h;
        int         cap;
        int         roll;
        int         rim;
        cap = eff_side / 5;
        if (cap > 16 * eff_step)
            cap = 16 * eff_step;
        w    = 9'($urandom_range(0, cap));
        h    = 9'($urandom_range(0, cap));
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            send_item(MODE_CLEAR, 9'($urandom()), 9'($urandom()));
        end
        else
        begin
            if (roll < 16)
            begin
                rim = eff_side - $urandom_range(2, 3);
                if ($urandom_range(0, 1))
                    w = 9'(rim);
                else
                    h = 9'(rim);
            end
            else if (roll < 30 && (eff_side <= 64 || eff_step >= 32))
            begin
                w = 9'($urandom());
                h = 9'($urandom());
            end
            send_item(gffrp_pkg::MODE_PLACE, w, h);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd511, 9'd511);
        send_item(gffrp_pkg::MODE_PLACE, 9'd509, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd509);
        send_item(MODE_CLEAR, 9'h1FF, 9'h1FF);

        set_surface(16, 1);
        send_item(gffrp_pkg::MODE_PLACE, 9'd12, 9'd12);
        send_item(gffrp_pkg::MODE_PLACE, 9'd13, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd14, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'h155, 9'h0AA);
        send_item(gffrp_pkg::MODE_PLACE, 9'h0AA, 9'h155);
        send_item(MODE_CLEAR, 9'd0, 9'd0);

        set_surface(512, 128);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd383, 9'd383);
        send_item(gffrp_pkg::MODE_PLACE, 9'd509, 9'd509);
        send_item(MODE_CLEAR, 9'h0AA, 9'h155);
        send_item(gffrp_pkg::MODE_PLACE, 9'd509, 9'd509);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);

        set_surface(0, 0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd12, 9'd12);
        send_item(gffrp_pkg::MODE_PLACE, 9'd13, 9'd13);

        set_surface(1023, 129);
        send_item(gffrp_pkg::MODE_PLACE, 9'd0, 9'd0);
        send_item(gffrp_pkg::MODE_PLACE, 9'd509, 9'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 5)
            begin
                src_idle_pct = 47;
                snk_idle_pct = 6;
            end
            else if (p == 10)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            set_surface(side_set[p], step_set[p]);
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gffrp_pkg.sv
rtl/core/gffrp_map.sv
rtl/core/gffrp_scan.sv
rtl/core/grid_first_fit_rect_placer.sv
verif/rect_place_checker.sv
verif/tb.sv
